// ----- design/imu_quaternion_complementary_filter_macros.svh -----
// Assertion macros for the attitude filter.
`ifndef IMU_QUATERNION_COMPLEMENTARY_FILTER_MACROS_SVH
`define IMU_QUATERNION_COMPLEMENTARY_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IQCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IQCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/imuqcf_pkg.sv -----
// Shared types, constants and helpers of the attitude filter.
package imuqcf_pkg;

    localparam int NEWTON_STEPS_DEF = 3;

    localparam int OPA_W  = 35;
    localparam int OPB_W  = 33;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [1:0] CFG_PROP_GAIN     = 2'd0;
    localparam logic [1:0] CFG_INTEG_GAIN    = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd2;

    localparam logic [30:0] PROP_GAIN_RST     = 31'd8388608;
    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd4294967;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // seed line for the inverse square root, two pieces
    localparam logic [31:0] SEED_LO_C = 32'd1385126953;
    localparam logic [31:0] SEED_LO_K = 32'd297;
    localparam logic [31:0] SEED_HI_C = 32'd981400027;
    localparam logic [31:0] SEED_HI_K = 32'd106;
    localparam logic [39:0] THREE_Q30 = 40'd3221225472;

    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sh7fff_ffff);
    localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sh8000_0000);
    localparam logic signed [ACC_W-1:0] Q30_POS = ACC_W'(64'sh4000_0000);
    localparam logic signed [ACC_W-1:0] Q30_NEG = ACC_W'(-64'sh4000_0000);
    localparam logic signed [ACC_W-1:0] HV2_BASE = ACC_W'(-64'sh0800_0000_0000_0000);

    typedef struct packed {
        logic                     issue;
        logic                     use_base;
        logic                     neg;
        logic                     shr2;
        logic signed [OPA_W-1:0]  a;
        logic signed [OPB_W-1:0]  b;
        logic signed [ACC_W-1:0]  base;
    } mac_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fff_ffff;
        else if (v < S32_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- design/imu_quaternion_complementary_filter.sv -----
// Six-axis attitude filter top: sequencer around one shared multiply-accumulate unit.
// Sequence: each multiply-accumulate step runs issue, product, then accumulate/write back;
//   24 + 3 * NEWTON_STEPS steps with zero accel, 52 + 6 * NEWTON_STEPS with correction
//   and a non-negative integral gain, plus a shift search per inverse square root.
// Throughput: one item at a time; a new sample is taken only once the last one is done.
// Reset: attitude to identity, bias integral to zero, gains and period to their defaults.
`include "imu_quaternion_complementary_filter_macros.svh"
module imu_quaternion_complementary_filter #(
    parameter int NEWTON_STEPS = imuqcf_pkg::NEWTON_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z,
    output logic               accel_used
);
    import imuqcf_pkg::*;

    localparam int NSW = $clog2(NEWTON_STEPS + 1);

    // One state per kind of step; idx picks the axis, term the product within a sum.
    typedef enum logic [4:0] {
        S_IDLE, S_ASQ, S_NRM, S_SEED, S_NT, S_NU, S_NY, S_ANRM, S_HV, S_ERR,
        S_IT, S_IB, S_PROP, S_HALF, S_QN, S_QSQ, S_QOUT, S_DONE
    } state_t;

    state_t state_reg;
    logic   wait_reg;
    logic [1:0] idx_reg;
    logic [1:0] term_reg;
    logic [NSW-1:0] newt_reg;
    logic   isq_quat_reg;     // inverse root serves the quaternion, not the accel

    // configuration
    logic [30:0]        prop_gain_reg;
    logic signed [31:0] integ_gain_reg;
    logic [31:0]        sample_period_reg;

    // filter state
    logic signed [31:0] q_reg [4];
    logic signed [31:0] bias_reg [3];

    // per-item working registers
    logic signed [34:0] g_reg [3];
    logic signed [15:0] acl_reg [3];
    logic               used_reg;
    logic signed [31:0] an_reg [3];
    logic signed [32:0] hv_reg [3];
    logic signed [31:0] e_reg [3];
    logic signed [31:0] h_reg [3];
    logic signed [31:0] r_reg [4];
    logic signed [31:0] tq_reg;
    logic [31:0]        y_reg;
    logic [33:0]        t_reg;
    logic [32:0]        d_reg;
    logic [63:0]        nm_reg;

    // output register
    logic               oval_reg;
    logic signed [31:0] ow_reg, ox_reg, oy_reg, oz_reg;
    logic               oused_reg;

    mac_req_t                req;
    logic signed [ACC_W-1:0] acc;
    logic                    mac_done;
    logic                    norm_start;
    logic [31:0]             nf;
    logic signed [5:0]       nhalf;
    logic                    norm_done;

    imuqcf_mac u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .acc  (acc),
        .done (mac_done)
    );

    imuqcf_norm u_norm (
        .clk  (clk),
        .rst_n(rst_n),
        .start(norm_start),
        .m    (nm_reg),
        .f    (nf),
        .half (nhalf),
        .done (norm_done)
    );

    logic ki_neg;
    logic mac_state;
    assign ki_neg = integ_gain_reg[31];

    // ---------------- operand selection (fixed taps per case arm) ----------------
    logic signed [31:0] e_sel, b_sel, r_i_sel, q_i_sel, r_t_sel;
    logic signed [34:0] g_sel;
    logic signed [15:0] acl_i_sel, acl_t_sel;
    logic [16:0]        mag_sel;

    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                e_sel = e_reg[0]; b_sel = bias_reg[0]; g_sel = g_reg[0];
                acl_i_sel = acl_reg[0]; r_i_sel = r_reg[0]; q_i_sel = q_reg[0];
            end
            2'd1:
            begin
                e_sel = e_reg[1]; b_sel = bias_reg[1]; g_sel = g_reg[1];
                acl_i_sel = acl_reg[1]; r_i_sel = r_reg[1]; q_i_sel = q_reg[1];
            end
            2'd2:
            begin
                e_sel = e_reg[2]; b_sel = bias_reg[2]; g_sel = g_reg[2];
                acl_i_sel = acl_reg[2]; r_i_sel = r_reg[2]; q_i_sel = q_reg[2];
            end
            default:
            begin
                e_sel = e_reg[2]; b_sel = bias_reg[2]; g_sel = g_reg[2];
                acl_i_sel = acl_reg[2]; r_i_sel = r_reg[3]; q_i_sel = q_reg[3];
            end
        endcase
        case (term_reg)
            2'd0:    begin acl_t_sel = acl_reg[0]; r_t_sel = r_reg[0]; end
            2'd1:    begin acl_t_sel = acl_reg[1]; r_t_sel = r_reg[1]; end
            2'd2:    begin acl_t_sel = acl_reg[2]; r_t_sel = r_reg[2]; end
            default: begin acl_t_sel = acl_reg[2]; r_t_sel = r_reg[3]; end
        endcase
        mag_sel = acl_i_sel[15] ? 17'(-$signed(17'(acl_i_sel))) : 17'(acl_i_sel);
    end

    logic signed [OPA_W-1:0] a_y, b_dummy_unused;
    logic signed [OPB_W-1:0] b_y, b_sp;
    assign a_y = $signed(OPA_W'(y_reg));
    assign b_y = $signed(OPB_W'(y_reg));
    assign b_sp = $signed(OPB_W'(sample_period_reg));
    assign b_dummy_unused = '0;

    always_comb
    begin
        req          = '0;
        mac_state    = 1'b1;
        case (state_reg)
            S_ASQ:
            begin
                req.a = OPA_W'(acl_t_sel);
                req.b = OPB_W'(acl_t_sel);
                req.use_base = (term_reg == 2'd0);
            end
            S_SEED:
            begin
                req.a = $signed(OPA_W'(nf));
                req.b = nf[31] ? $signed(OPB_W'(SEED_HI_K)) : $signed(OPB_W'(SEED_LO_K));
                req.use_base = 1'b1;
            end
            S_NT:
            begin
                req.a = a_y;
                req.b = b_y;
                req.use_base = 1'b1;
            end
            S_NU:
            begin
                req.a = $signed(OPA_W'(t_reg));
                req.b = $signed(OPB_W'(nf));
                req.use_base = 1'b1;
            end
            S_NY:
            begin
                req.a = a_y;
                req.b = $signed(d_reg);
                req.use_base = 1'b1;
            end
            S_ANRM:
            begin
                req.a = $signed(OPA_W'(mag_sel));
                req.b = b_y;
                req.use_base = 1'b1;
            end
            S_HV:
            begin
                req.use_base = (term_reg == 2'd0);
                case ({idx_reg, term_reg[0]})
                    3'b000:  begin req.a = OPA_W'(q_reg[1]); req.b = OPB_W'(q_reg[3]); end
                    3'b001:
                    begin
                        req.a = OPA_W'(q_reg[0]); req.b = OPB_W'(q_reg[2]); req.neg = 1'b1;
                    end
                    3'b010:  begin req.a = OPA_W'(q_reg[0]); req.b = OPB_W'(q_reg[1]); end
                    3'b011:  begin req.a = OPA_W'(q_reg[2]); req.b = OPB_W'(q_reg[3]); end
                    3'b100:
                    begin
                        req.a = OPA_W'(q_reg[0]); req.b = OPB_W'(q_reg[0]);
                        req.base = HV2_BASE;
                    end
                    default: begin req.a = OPA_W'(q_reg[3]); req.b = OPB_W'(q_reg[3]); end
                endcase
            end
            S_ERR:
            begin
                req.use_base = (term_reg == 2'd0);
                case ({idx_reg, term_reg[0]})
                    3'b000:  begin req.a = OPA_W'(an_reg[1]); req.b = OPB_W'(hv_reg[2]); end
                    3'b001:
                    begin
                        req.a = OPA_W'(an_reg[2]); req.b = OPB_W'(hv_reg[1]); req.neg = 1'b1;
                    end
                    3'b010:  begin req.a = OPA_W'(an_reg[2]); req.b = OPB_W'(hv_reg[0]); end
                    3'b011:
                    begin
                        req.a = OPA_W'(an_reg[0]); req.b = OPB_W'(hv_reg[2]); req.neg = 1'b1;
                    end
                    3'b100:  begin req.a = OPA_W'(an_reg[0]); req.b = OPB_W'(hv_reg[1]); end
                    default:
                    begin
                        req.a = OPA_W'(an_reg[1]); req.b = OPB_W'(hv_reg[0]); req.neg = 1'b1;
                    end
                endcase
            end
            S_IT:
            begin
                req.a = OPA_W'(e_sel);
                req.b = b_sp;
                req.use_base = 1'b1;
            end
            S_IB:
            begin
                req.a = OPA_W'(integ_gain_reg);
                req.b = OPB_W'(tq_reg);
                req.use_base = 1'b1;
                req.base = ACC_W'(b_sel) <<< 30;
            end
            S_PROP:
            begin
                req.a = $signed(OPA_W'(prop_gain_reg));
                req.b = OPB_W'(e_sel);
                req.use_base = 1'b1;
                req.base = (ACC_W'(g_sel) + ACC_W'(b_sel)) <<< 30;
            end
            S_HALF:
            begin
                req.a = OPA_W'(g_sel);
                req.b = b_sp;
                req.use_base = 1'b1;
            end
            S_QN:
            begin
                req.use_base = (term_reg == 2'd0);
                req.base = ACC_W'(q_i_sel) <<< 30;
                case ({idx_reg, term_reg})
                    4'b0000: begin req.a = OPA_W'(q_reg[1]); req.b = OPB_W'(h_reg[0]); req.neg = 1'b1; end
                    4'b0001: begin req.a = OPA_W'(q_reg[2]); req.b = OPB_W'(h_reg[1]); req.neg = 1'b1; end
                    4'b0010: begin req.a = OPA_W'(q_reg[3]); req.b = OPB_W'(h_reg[2]); req.neg = 1'b1; end
                    4'b0100: begin req.a = OPA_W'(q_reg[0]); req.b = OPB_W'(h_reg[0]); end
                    4'b0101: begin req.a = OPA_W'(q_reg[2]); req.b = OPB_W'(h_reg[2]); end
                    4'b0110: begin req.a = OPA_W'(q_reg[3]); req.b = OPB_W'(h_reg[1]); req.neg = 1'b1; end
                    4'b1000: begin req.a = OPA_W'(q_reg[0]); req.b = OPB_W'(h_reg[1]); end
                    4'b1001: begin req.a = OPA_W'(q_reg[1]); req.b = OPB_W'(h_reg[2]); req.neg = 1'b1; end
                    4'b1010: begin req.a = OPA_W'(q_reg[3]); req.b = OPB_W'(h_reg[0]); end
                    4'b1100: begin req.a = OPA_W'(q_reg[0]); req.b = OPB_W'(h_reg[2]); end
                    4'b1101: begin req.a = OPA_W'(q_reg[1]); req.b = OPB_W'(h_reg[1]); end
                    default: begin req.a = OPA_W'(q_reg[2]); req.b = OPB_W'(h_reg[0]); req.neg = 1'b1; end
                endcase
            end
            S_QSQ:
            begin
                req.a = OPA_W'(r_t_sel);
                req.b = OPB_W'(r_t_sel);
                req.shr2 = 1'b1;
                req.use_base = (term_reg == 2'd0);
            end
            S_QOUT:
            begin
                req.a = OPA_W'(r_i_sel);
                req.b = b_y;
                req.use_base = 1'b1;
            end
            default: mac_state = 1'b0;
        endcase
        req.issue = mac_state && !wait_reg && !((state_reg == S_IT) && ki_neg)
                    && (b_dummy_unused == '0);
    end

    assign norm_start = (state_reg == S_NRM) && !wait_reg;

    // ---------------- write-back helpers ----------------
    logic signed [5:0]       shamt6;
    logic [4:0]              shamt;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [ACC_W-1:0] acc_q30;
    logic [39:0]             u_val;
    logic signed [ACC_W-1:0] an_mag;
    logic signed [31:0]      an_val;
    logic signed [31:0]      qo_val;

    always_comb
    begin
        shamt6  = ((state_reg == S_QOUT) ? 6'sd16 : 6'sd15) + nhalf;
        shamt   = shamt6[4:0];
        acc_sh  = acc >>> shamt;
        acc_q30 = acc >>> 30;
        u_val   = acc[69:30];
        an_mag  = (acc_sh > Q30_POS) ? Q30_POS : acc_sh;
        an_val  = acl_i_sel[15] ? -an_mag[31:0] : an_mag[31:0];
        if (acc_sh > Q30_POS)
            qo_val = ONE_Q30;
        else if (acc_sh < Q30_NEG)
            qo_val = -ONE_Q30;
        else
            qo_val = acc_sh[31:0];
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= '0;
            sample_period_reg <= SAMPLE_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data[30:0];
                CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wait_reg     <= 1'b0;
            idx_reg      <= '0;
            term_reg     <= '0;
            newt_reg     <= '0;
            isq_quat_reg <= 1'b0;
            oval_reg     <= 1'b0;
            q_reg[0]     <= ONE_Q30;
            q_reg[1]     <= '0;
            q_reg[2]     <= '0;
            q_reg[3]     <= '0;
            bias_reg[0]  <= '0;
            bias_reg[1]  <= '0;
            bias_reg[2]  <= '0;
        end
        else
        begin
            if (oval_reg && !out_stall)
                oval_reg <= 1'b0;
            if (req.issue || norm_start)
                wait_reg <= 1'b1;
            if (mac_done || norm_done)
                wait_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        g_reg[0]   <= 35'(rate_x);
                        g_reg[1]   <= 35'(rate_y);
                        g_reg[2]   <= 35'(rate_z);
                        acl_reg[0] <= accel_x;
                        acl_reg[1] <= accel_y;
                        acl_reg[2] <= accel_z;
                        used_reg   <= (accel_x != 16'sd0) || (accel_y != 16'sd0)
                                      || (accel_z != 16'sd0);
                        idx_reg    <= '0;
                        term_reg   <= '0;
                        if ((accel_x != 16'sd0) || (accel_y != 16'sd0) || (accel_z != 16'sd0))
                            state_reg <= S_ASQ;
                        else
                            state_reg <= S_HALF;
                    end
                end
                S_ASQ:
                begin
                    if (mac_done)
                    begin
                        if (term_reg == 2'd2)
                        begin
                            nm_reg       <= acc[63:0];
                            isq_quat_reg <= 1'b0;
                            term_reg     <= '0;
                            state_reg    <= S_NRM;
                        end
                        else
                            term_reg <= term_reg + 2'd1;
                    end
                end
                S_NRM:
                begin
                    if (norm_done)
                        state_reg <= S_SEED;
                end
                S_SEED:
                begin
                    if (mac_done)
                    begin
                        y_reg     <= (nf[31] ? SEED_HI_C : SEED_LO_C) - acc[41:10];
                        newt_reg  <= '0;
                        state_reg <= S_NT;
                    end
                end
                S_NT:
                begin
                    if (mac_done)
                    begin
                        t_reg     <= acc[63:30];
                        state_reg <= S_NU;
                    end
                end
                S_NU:
                begin
                    if (mac_done)
                    begin
                        d_reg     <= (u_val < THREE_Q30) ? 33'(THREE_Q30 - u_val) : '0;
                        state_reg <= S_NY;
                    end
                end
                S_NY:
                begin
                    if (mac_done)
                    begin
                        y_reg <= acc[62:31];
                        if (newt_reg == NSW'(NEWTON_STEPS - 1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= isq_quat_reg ? S_QOUT : S_ANRM;
                        end
                        else
                        begin
                            newt_reg  <= newt_reg + 1'b1;
                            state_reg <= S_NT;
                        end
                    end
                end
                S_ANRM:
                begin
                    if (mac_done)
                    begin
                        an_reg[idx_reg] <= an_val;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            term_reg  <= '0;
                            state_reg <= S_HV;
                        end
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                end
                S_HV, S_ERR:
                begin
                    if (mac_done)
                    begin
                        if (term_reg == 2'd0)
                            term_reg <= 2'd1;
                        else
                        begin
                            term_reg <= '0;
                            if (state_reg == S_HV)
                                hv_reg[idx_reg] <= acc_q30[32:0];
                            else
                                e_reg[idx_reg] <= sat32(acc_q30);
                            if (idx_reg == 2'd2)
                            begin
                                idx_reg   <= '0;
                                state_reg <= (state_reg == S_HV) ? S_ERR : S_IT;
                            end
                            else
                                idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
                S_IT:
                begin
                    // negative ki: integral cleared and left out of the rate
                    if (ki_neg)
                    begin
                        bias_reg[idx_reg] <= '0;
                        state_reg         <= S_PROP;
                    end
                    else if (mac_done)
                    begin
                        tq_reg    <= acc[63:32];
                        state_reg <= S_IB;
                    end
                end
                S_IB:
                begin
                    if (mac_done)
                    begin
                        bias_reg[idx_reg] <= sat32(acc_q30);
                        state_reg         <= S_PROP;
                    end
                end
                S_PROP:
                begin
                    if (mac_done)
                    begin
                        g_reg[idx_reg] <= acc_q30[34:0];
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_HALF;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_IT;
                        end
                    end
                end
                S_HALF:
                begin
                    if (mac_done)
                    begin
                        h_reg[idx_reg] <= sat32(acc >>> 27);
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= '0;
                            term_reg  <= '0;
                            state_reg <= S_QN;
                        end
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                end
                S_QN:
                begin
                    if (mac_done)
                    begin
                        if (term_reg == 2'd2)
                        begin
                            term_reg       <= '0;
                            r_reg[idx_reg] <= sat32(acc_q30);
                            if (idx_reg == 2'd3)
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_QSQ;
                            end
                            else
                                idx_reg <= idx_reg + 2'd1;
                        end
                        else
                            term_reg <= term_reg + 2'd1;
                    end
                end
                S_QSQ:
                begin
                    if (mac_done)
                    begin
                        if (term_reg == 2'd3)
                        begin
                            term_reg <= '0;
                            if (acc == '0)
                            begin
                                // degenerate quaternion: back to identity
                                q_reg[0]  <= ONE_Q30;
                                q_reg[1]  <= '0;
                                q_reg[2]  <= '0;
                                q_reg[3]  <= '0;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                nm_reg       <= acc[63:0];
                                isq_quat_reg <= 1'b1;
                                state_reg    <= S_NRM;
                            end
                        end
                        else
                            term_reg <= term_reg + 2'd1;
                    end
                end
                S_QOUT:
                begin
                    if (mac_done)
                    begin
                        q_reg[idx_reg] <= qo_val;
                        if (idx_reg == 2'd3)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                end
                S_DONE:
                begin
                    if (!oval_reg || !out_stall)
                    begin
                        oval_reg  <= 1'b1;
                        ow_reg    <= q_reg[0];
                        ox_reg    <= q_reg[1];
                        oy_reg    <= q_reg[2];
                        oz_reg    <= q_reg[3];
                        oused_reg <= used_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = oval_reg;
    assign quat_w     = ow_reg;
    assign quat_x     = ox_reg;
    assign quat_y     = oy_reg;
    assign quat_z     = oz_reg;
    assign accel_used = oused_reg;

    // ---------------- assertions ----------------
    `IQCF_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg != S_IDLE, "accepted transfer did not start work")
    `IQCF_ASSERT_NOW(a_quat_range, out_valid, (quat_w <= ONE_Q30) && (quat_w >= -ONE_Q30), "quat_w out of unit range")
    `IQCF_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(state_reg) == S_DONE, "result raised outside done step")
    `IQCF_ASSERT_NOW(a_mac_tracked, mac_done, wait_reg, "multiplier finished with no step waiting")

endmodule

// ----- design/imuqcf_mac.sv -----
// Shared multiply-accumulate unit: product register, then accumulate.
module imuqcf_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imuqcf_pkg::mac_req_t                req,
    output logic signed [imuqcf_pkg::ACC_W-1:0] acc,
    output logic                                done
);
    import imuqcf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  base_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     stage_reg;
    logic                     done_reg;
    logic                     use_base_reg;
    logic                     neg_reg;
    logic                     shr2_reg;

    logic signed [PROD_W-1:0] term;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  sum;

    always_comb
    begin
        term     = shr2_reg ? (prod_reg >>> 2) : prod_reg;
        term_ext = ACC_W'(term);
        sum      = (use_base_reg ? base_reg : acc_reg) + (neg_reg ? -term_ext : term_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= req.issue;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            prod_reg     <= req.a * req.b;
            base_reg     <= req.base;
            use_base_reg <= req.use_base;
            neg_reg      <= req.neg;
            shr2_reg     <= req.shr2;
        end
        if (stage_reg)
            acc_reg <= sum;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ----- design/imuqcf_norm.sv -----
// Shift-search unit: moves an operand by even steps into [2^30, 2^32).
module imuqcf_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       m,
    output logic [31:0]       f,
    output logic signed [5:0] half,
    output logic              done
);
    logic [63:0]       f_reg;
    logic signed [5:0] half_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && (f_reg[63:32] == 32'd0) && (f_reg[31:30] != 2'd0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            f_reg    <= m;
            half_reg <= 6'sd0;
        end
        else if (busy_reg)
        begin
            if (f_reg[63:32] != 32'd0)
            begin
                f_reg    <= f_reg >> 2;
                half_reg <= half_reg + 6'sd1;
            end
            else if (f_reg[31:30] == 2'd0)
            begin
                f_reg    <= f_reg << 2;
                half_reg <= half_reg - 6'sd1;
            end
        end
    end

    assign f    = f_reg[31:0];
    assign half = half_reg;
    assign done = done_reg;

endmodule
